// File: rtl/dwarf_cfa_instruction_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the call-frame instruction decoder
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef DWARF_CFA_INSTRUCTION_DECODER_ASSERT_SVH
`define DWARF_CFA_INSTRUCTION_DECODER_ASSERT_SVH
`ifndef SYNTH
`define DCFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcfa check failed");
`define DCFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcfa check failed");
`else
`define DCFA_ASSERT_IMPL(label, ante, cons)
`define DCFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/dcfa_pkg.sv
// ---------------------------------------------------------------------------
// dcfa_pkg
// Shared types and constants of the call-frame instruction decoder.
// ---------------------------------------------------------------------------
package dcfa_pkg;

    localparam int unsigned MAX_TRY_DEPTH = 20;
    localparam int unsigned TRY_W = 5;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIXED = 2'd1,
        PH_LEB   = 2'd2
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_OP    = 3'd1;
    localparam logic [2:0] ST_BAD_SEH   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_END_NOTRY = 3'd4;

    localparam logic [2:0] SEH_NONE   = 3'd0;
    localparam logic [2:0] SEH_BEGIN  = 3'd1;
    localparam logic [2:0] SEH_END    = 3'd4;
    localparam logic [2:0] SEH_FCONST = 3'd5;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_SET_LOC  = 8'h01;
    localparam logic [7:0] OP_ADV1     = 8'h02;
    localparam logic [7:0] OP_ADV2     = 8'h03;
    localparam logic [7:0] OP_ADV4     = 8'h04;
    localparam logic [7:0] OP_OFS_EXT  = 8'h05;
    localparam logic [7:0] OP_RESTX    = 8'h06;
    localparam logic [7:0] OP_UNDEF    = 8'h07;
    localparam logic [7:0] OP_SAMEV    = 8'h08;
    localparam logic [7:0] OP_REGCPY   = 8'h09;
    localparam logic [7:0] OP_REMEMBER = 8'h0a;
    localparam logic [7:0] OP_RESTORE  = 8'h0b;
    localparam logic [7:0] OP_DEF_CFA  = 8'h0c;
    localparam logic [7:0] OP_DEF_REG  = 8'h0d;
    localparam logic [7:0] OP_DEF_OFS  = 8'h0e;
    localparam logic [7:0] OP_OFS_SF   = 8'h11;
    localparam logic [7:0] OP_CFA_SF   = 8'h12;
    localparam logic [7:0] OP_SEH      = 8'h21;
    localparam logic [7:0] OP_ARGS     = 8'h2e;
    localparam logic [7:0] OP_ADV_LOC  = 8'h40;
    localparam logic [7:0] OP_OFFSET   = 8'h80;
    localparam logic [7:0] OP_RESTORE6 = 8'hc0;

    typedef struct packed {
        logic [7:0]  op_code;
        logic [31:0] location;
        logic [31:0] reg_number;
        logic [31:0] second_reg;
        logic [31:0] save_offset;
        logic [31:0] cfa_offset;
        logic [31:0] cfa_delta;
        logic        is_unwind_op;
        logic [2:0]  seh_event;
        logic [4:0]  try_depth;
        logic [31:0] aux_value;
        logic [2:0]  status;
    } result_t;

endpackage

// File: rtl/dcfa_out_slot.sv
// ---------------------------------------------------------------------------
// dcfa_out_slot
// Result register with a skid entry so the decoder keeps taking bytes.
// ---------------------------------------------------------------------------
module dcfa_out_slot
    import dcfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_v_reg, skid_v_reg;
    result_t main_reg, skid_reg;
    logic    pop;

    assign pop       = main_v_reg && out_ready;
    assign can_take  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!main_v_reg || pop)
            begin
                main_v_reg <= skid_v_reg || push;
                skid_v_reg <= skid_v_reg && push;
            end
            else if (push)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || pop)
        begin
            main_reg <= skid_v_reg ? skid_reg : push_data;
            if (skid_v_reg && push)
                skid_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

// File: rtl/dwarf_cfa_instruction_decoder.sv
// ---------------------------------------------------------------------------
// dwarf_cfa_instruction_decoder
// Byte-serial decoder of DWARF call-frame instructions.
// ---------------------------------------------------------------------------
// One stream byte is taken per cycle, back to back. The decode state is
// updated in the cycle of the transfer by short logic, and a finished
// instruction drops one result into a two-entry output slot; bytes inside
// an instruction give no result. Bytes are taken whenever the slot has room,
// so stalls on the result side cost throughput only once both entries fill.
// A result with nonzero status latches an error and later bytes are dropped
// until a byte arrives with start_sequence set.
module dwarf_cfa_instruction_decoder
    import dcfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_sequence,
    input  logic [31:0] base_location,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  op_code,
    output logic [31:0] location,
    output logic [31:0] reg_number,
    output logic [31:0] second_reg,
    output logic signed [31:0] save_offset,
    output logic signed [31:0] cfa_offset,
    output logic signed [31:0] cfa_delta,
    output logic        is_unwind_op,
    output logic [2:0]  seh_event,
    output logic [4:0]  try_depth,
    output logic [31:0] aux_value,
    output logic [2:0]  status
);

`include "dwarf_cfa_instruction_decoder_assert.svh"

    phase_t      phase_reg, phase_next;
    logic [7:0]  op_reg, op_next;
    logic        oidx_reg, oidx_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  sh_reg, sh_next;
    logic [31:0] loc_reg, loc_next;
    logic [31:0] r1_reg, r1_next;
    logic [31:0] r2_reg, r2_next;
    logic [31:0] ofs_reg, ofs_next;
    logic [31:0] frm_reg, frm_next;
    logic [31:0] prv_reg, prv_next;
    logic [TRY_W-1:0] try_reg, try_next;
    logic        err_reg, err_next;

    logic        take, push, can_take;
    result_t     res, out_r;

    // working copies after the start clear
    phase_t      ph;
    logic [7:0]  op;
    logic        oi;
    logic [3:0]  cn;
    logic [31:0] ac;
    logic [5:0]  sh;
    logic        er;
    logic [31:0] u, s, accx, frmx, prvx;
    logic [3:0]  cnt1, flen;
    logic [6:0]  sh7;
    logic        emit;
    logic [7:0]  e_op;
    logic        e_uw;
    logic [2:0]  e_ev, e_st;
    logic [31:0] e_aux;

    assign take     = in_valid && in_ready;
    assign in_ready = can_take;

    always_comb
    begin
        ph = phase_reg; op = op_reg; oi = oidx_reg; cn = cnt_reg; ac = acc_reg;
        sh = sh_reg; er = err_reg;
        loc_next = loc_reg; r1_next = r1_reg; r2_next = r2_reg; ofs_next = ofs_reg;
        frmx = frm_reg; prvx = prv_reg; try_next = try_reg;
        if (start_sequence)
        begin
            ph = PH_IDLE; op = 8'h00; oi = 1'b0; cn = 4'd0; ac = 32'd0; sh = 6'd0;
            frmx = 32'd0; prvx = 32'd0; try_next = '0; er = 1'b0;
            loc_next = base_location;
        end
        phase_next = ph; op_next = op; oidx_next = oi; cnt_next = cn;
        acc_next = ac; sh_next = sh; err_next = er;
        frm_next = frmx; prv_next = prvx;
        emit = 1'b0; e_op = op; e_uw = 1'b0; e_ev = SEH_NONE; e_aux = 32'd0;
        e_st = ST_OK;
        u = 32'd0; s = 32'd0; accx = ac; cnt1 = cn + 4'd1; sh7 = 7'd0;
        flen = (op == OP_SET_LOC) ? 4'd8 : (op == OP_ADV1) ? 4'd1 :
               (op == OP_ADV2) ? 4'd2 : 4'd4;
        if (!er)
        begin
            case (ph)
                PH_FIXED:
                begin
                    case (cn[1:0])
                        2'd0: accx[7:0]   = ac[7:0]   | data_byte;
                        2'd1: accx[15:8]  = ac[15:8]  | data_byte;
                        2'd2: accx[23:16] = ac[23:16] | data_byte;
                        default: accx[31:24] = ac[31:24] | data_byte;
                    endcase
                    if (cn[3:2] != 2'd0)
                        accx = ac;
                    acc_next = accx;
                    cnt_next = cnt1;
                    if (cnt1 >= flen)
                    begin
                        loc_next = (op == OP_SET_LOC) ? accx : loc_next + accx;
                        emit = 1'b1;
                    end
                end
                PH_LEB:
                begin
                    if (sh < 6'd32)
                        accx = ac | ({25'd0, data_byte[6:0]} << sh[4:0]);
                    sh7 = {1'b0, sh} + 7'd7;
                    sh_next = (sh7 > 7'd35) ? 6'd35 : sh7[5:0];
                    acc_next = accx;
                    if (!data_byte[7])
                    begin
                        u = accx;
                        s = accx;
                        if (data_byte[6] && sh_next < 6'd32)
                            s = accx | (32'hffffffff << sh_next[4:0]);
                        acc_next = 32'd0;
                        sh_next = 6'd0;
                        emit = 1'b1;
                        case (op)
                            OP_OFFSET:
                            begin
                                ofs_next = {u[28:0], 3'b000}; e_uw = 1'b1;
                            end
                            OP_OFS_EXT, OP_OFS_SF:
                            begin
                                if (!oi)
                                begin
                                    r1_next = u; emit = 1'b0;
                                end
                                else
                                begin
                                    ofs_next = (op == OP_OFS_SF) ? s : u; e_uw = 1'b1;
                                end
                            end
                            OP_RESTX, OP_UNDEF, OP_SAMEV, OP_DEF_REG: r1_next = u;
                            OP_REGCPY:
                            begin
                                if (!oi)
                                begin
                                    r1_next = u; emit = 1'b0;
                                end
                                else
                                    r2_next = u;
                            end
                            OP_DEF_CFA, OP_CFA_SF:
                            begin
                                if (!oi)
                                begin
                                    r1_next = u; emit = 1'b0;
                                end
                                else
                                begin
                                    frm_next = (op == OP_CFA_SF) ? {s[28:0], 3'b000} : u;
                                    e_uw = 1'b1;
                                end
                            end
                            OP_DEF_OFS:
                            begin
                                frm_next = u; e_uw = 1'b1;
                            end
                            OP_ARGS: e_aux = u;
                            default:
                            begin
                                if (oi)
                                begin
                                    e_ev = SEH_FCONST; e_aux = u;
                                end
                                else if (u == 32'd1)
                                begin
                                    e_ev = SEH_BEGIN;
                                    if ({27'd0, try_reg} + 32'd1 >= MAX_TRY_DEPTH)
                                        e_st = ST_OVERFLOW;
                                    else
                                        try_next = try_reg + 1'b1;
                                end
                                else if (u == 32'd4)
                                begin
                                    e_ev = SEH_END;
                                    if (try_next == '0)
                                        e_st = ST_END_NOTRY;
                                    else
                                        try_next = try_next - 1'b1;
                                end
                                else if (u == 32'd5)
                                    emit = 1'b0;
                                else if (u == 32'd2 || u == 32'd3 || u == 32'd6 ||
                                         u == 32'd7)
                                    e_ev = u[2:0];
                                else
                                    e_st = ST_BAD_SEH;
                            end
                        endcase
                        if (!emit)
                            oidx_next = 1'b1;
                    end
                end
                default:
                begin
                    op_next = data_byte; oi = 1'b0; oidx_next = 1'b0;
                    cnt_next = 4'd0; acc_next = 32'd0; sh_next = 6'd0;
                    prv_next = frmx;
                    e_op = data_byte;
                    case (data_byte[7:6])
                        2'b01:
                        begin
                            loc_next = loc_next + {26'd0, data_byte[5:0]};
                            e_op = OP_ADV_LOC; emit = 1'b1;
                        end
                        2'b10:
                        begin
                            r1_next = {26'd0, data_byte[5:0]};
                            op_next = OP_OFFSET; phase_next = PH_LEB;
                        end
                        2'b11:
                        begin
                            r1_next = {26'd0, data_byte[5:0]};
                            e_op = OP_RESTORE6; emit = 1'b1;
                        end
                        default:
                        begin
                            case (data_byte)
                                OP_NOP, OP_REMEMBER, OP_RESTORE: emit = 1'b1;
                                OP_SET_LOC, OP_ADV1, OP_ADV2, OP_ADV4:
                                    phase_next = PH_FIXED;
                                OP_OFS_EXT, OP_RESTX, OP_UNDEF, OP_SAMEV, OP_REGCPY,
                                OP_DEF_CFA, OP_DEF_REG, OP_DEF_OFS, OP_OFS_SF,
                                OP_CFA_SF, OP_SEH, OP_ARGS:
                                    phase_next = PH_LEB;
                                default:
                                begin
                                    emit = 1'b1; e_st = ST_BAD_OP;
                                end
                            endcase
                        end
                    endcase
                end
            endcase
            if (emit)
            begin
                phase_next = PH_IDLE; op_next = 8'h00; oidx_next = 1'b0;
                cnt_next = 4'd0; acc_next = 32'd0; sh_next = 6'd0;
                if (e_st != ST_OK)
                    err_next = 1'b1;
            end
        end
        res.op_code      = e_op;
        res.location     = loc_next;
        res.reg_number   = r1_next;
        res.second_reg   = r2_next;
        res.save_offset  = ofs_next;
        res.cfa_offset   = frm_next;
        res.cfa_delta    = frm_next - prv_next;
        res.is_unwind_op = e_uw;
        res.seh_event    = e_ev;
        res.try_depth    = try_next;
        res.aux_value    = e_aux;
        res.status       = e_st;
    end

    assign push = take && emit;

    // advance decode state on every byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; op_reg <= 8'h00; oidx_reg <= 1'b0; cnt_reg <= 4'd0;
            acc_reg <= 32'd0; sh_reg <= 6'd0; loc_reg <= 32'd0; r1_reg <= 32'd0;
            r2_reg <= 32'd0; ofs_reg <= 32'd0; frm_reg <= 32'd0; prv_reg <= 32'd0;
            try_reg <= '0; err_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next; op_reg <= op_next; oidx_reg <= oidx_next;
            cnt_reg <= cnt_next; acc_reg <= acc_next; sh_reg <= sh_next;
            loc_reg <= loc_next; r1_reg <= r1_next; r2_reg <= r2_next;
            ofs_reg <= ofs_next; frm_reg <= frm_next; prv_reg <= prv_next;
            try_reg <= try_next; err_reg <= err_next;
        end
    end

    dcfa_out_slot u_slot (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_r)
    );

    assign op_code      = out_r.op_code;
    assign location     = out_r.location;
    assign reg_number   = out_r.reg_number;
    assign second_reg   = out_r.second_reg;
    assign save_offset  = out_r.save_offset;
    assign cfa_offset   = out_r.cfa_offset;
    assign cfa_delta    = out_r.cfa_delta;
    assign is_unwind_op = out_r.is_unwind_op;
    assign seh_event    = out_r.seh_event;
    assign try_depth    = out_r.try_depth;
    assign aux_value    = out_r.aux_value;
    assign status       = out_r.status;

    `DCFA_ASSERT_IMPL(a_try_bound, 1'b1, try_reg < MAX_TRY_DEPTH)
    `DCFA_ASSERT_NEXT(a_err_drop, take && err_reg && !start_sequence, !u_slot.skid_v_reg || $past(u_slot.skid_v_reg))
    `DCFA_ASSERT_IMPL(a_ok_no_err, push && res.status == ST_OK, err_next == err_reg || start_sequence)

endmodule

// File: sim/dwarf_cfa_instruction_decoder_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Call-frame decoder result checker
// Watches both channels, predicts each result from the accepted bytes and
// compares the results field by field, in order.
// ---------------------------------------------------------------------------
module dwarf_cfa_instruction_decoder_checker
    import dcfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_sequence,
    input  logic [31:0] base_location,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  op_code,
    input  logic [31:0] location,
    input  logic [31:0] reg_number,
    input  logic [31:0] second_reg,
    input  logic [31:0] save_offset,
    input  logic [31:0] cfa_offset,
    input  logic [31:0] cfa_delta,
    input  logic        is_unwind_op,
    input  logic [2:0]  seh_event,
    input  logic [4:0]  try_depth,
    input  logic [31:0] aux_value,
    input  logic [2:0]  status,
    output int          fail_count,
    output int          pending_results
);

    phase_t      dec_phase;
    logic [7:0]  cur_op;
    int unsigned opnd_idx;
    int unsigned fix_count;
    logic [31:0] accum;
    int unsigned shift_amt;
    logic [31:0] loc_q, reg_q, reg2_q, ofs_q, frame_q, frame_prev;
    int unsigned level_q;
    logic        err_q;
    result_t     expected_results[$];

    function automatic int unsigned fixed_bytes(logic [7:0] op);
        return op == OP_SET_LOC ? 8 : op == OP_ADV1 ? 1 : op == OP_ADV2 ? 2 : 4;
    endfunction

    task automatic clear_decode();
        dec_phase = PH_IDLE;
        cur_op    = OP_NOP;
        opnd_idx  = 0;
        fix_count = 0;
        accum     = '0;
        shift_amt = 0;
    endtask

    task automatic push_result(logic [7:0] op, logic uw, logic [2:0] ev, logic [31:0] aux,
                               logic [2:0] st);
        result_t r;
        r.op_code      = op;
        r.location     = loc_q;
        r.reg_number   = reg_q;
        r.second_reg   = reg2_q;
        r.save_offset  = ofs_q;
        r.cfa_offset   = frame_q;
        r.cfa_delta    = frame_q - frame_prev;
        r.is_unwind_op = uw;
        r.seh_event    = ev;
        r.try_depth    = level_q[4:0];
        r.aux_value    = aux;
        r.status       = st;
        expected_results.push_back(r);
        clear_decode();
        if (st != ST_OK)
            err_q = 1'b1;
    endtask

    task automatic finish_operand(logic [31:0] u, logic [31:0] s);
        logic first;
        first = (opnd_idx == 0);
        case (cur_op)
            OP_OFFSET:
            begin
                ofs_q = u << 3;
                push_result(cur_op, 1, SEH_NONE, 0, ST_OK);
            end
            OP_OFS_EXT, OP_OFS_SF, OP_REGCPY, OP_DEF_CFA, OP_CFA_SF:
            begin
                if (first)
                begin
                    reg_q = u;
                    opnd_idx++;
                end
                else
                begin
                    if (cur_op == OP_OFS_EXT) ofs_q = u;
                    else if (cur_op == OP_OFS_SF) ofs_q = s;
                    else if (cur_op == OP_REGCPY) reg2_q = u;
                    else if (cur_op == OP_DEF_CFA) frame_q = u;
                    else frame_q = s << 3;
                    push_result(cur_op, cur_op != OP_REGCPY, SEH_NONE, 0, ST_OK);
                end
            end
            OP_RESTX, OP_UNDEF, OP_SAMEV, OP_DEF_REG:
            begin
                reg_q = u;
                push_result(cur_op, 0, SEH_NONE, 0, ST_OK);
            end
            OP_DEF_OFS:
            begin
                frame_q = u;
                push_result(cur_op, 1, SEH_NONE, 0, ST_OK);
            end
            OP_ARGS: push_result(cur_op, 0, SEH_NONE, u, ST_OK);
            default:
            begin
                // SEH: second operand is the filter constant
                if (!first)
                    push_result(cur_op, 0, SEH_FCONST, u, ST_OK);
                else if (u == SEH_BEGIN)
                begin
                    if (level_q + 1 >= MAX_TRY_DEPTH)
                        push_result(cur_op, 0, SEH_BEGIN, 0, ST_OVERFLOW);
                    else
                    begin
                        level_q++;
                        push_result(cur_op, 0, SEH_BEGIN, 0, ST_OK);
                    end
                end
                else if (u == SEH_END)
                begin
                    if (level_q == 0)
                        push_result(cur_op, 0, SEH_END, 0, ST_END_NOTRY);
                    else
                    begin
                        level_q--;
                        push_result(cur_op, 0, SEH_END, 0, ST_OK);
                    end
                end
                else if (u == SEH_FCONST)
                    opnd_idx++;
                else if (u == 2 || u == 3 || u == 6 || u == 7)
                    push_result(cur_op, 0, u[2:0], 0, ST_OK);
                else
                    push_result(cur_op, 0, SEH_NONE, 0, ST_BAD_SEH);
            end
        endcase
    endtask

    task automatic take_byte(logic [7:0] b, logic strt, logic [31:0] base);
        logic [31:0] u, s;
        if (strt)
        begin
            clear_decode();
            frame_q = 0; frame_prev = 0; level_q = 0; err_q = 0;
            loc_q = base;
        end
        if (err_q)
            return;
        if (dec_phase == PH_FIXED)
        begin
            if (fix_count < 4)
                accum |= 32'(b) << (8 * fix_count);
            fix_count++;
            if (fix_count >= fixed_bytes(cur_op))
            begin
                loc_q = (cur_op == OP_SET_LOC) ? accum : loc_q + accum;
                push_result(cur_op, 0, SEH_NONE, 0, ST_OK);
            end
        end
        else if (dec_phase == PH_LEB)
        begin
            if (shift_amt < 32)
                accum |= 32'(b[6:0]) << shift_amt;
            shift_amt = (shift_amt + 7 > 35) ? 35 : shift_amt + 7;
            if (!b[7])
            begin
                u = accum;
                s = u;
                if (b[6] && shift_amt < 32)
                    s |= 32'hffff_ffff << shift_amt;
                accum = 0;
                shift_amt = 0;
                finish_operand(u, s);
            end
        end
        else
        begin
            clear_decode();
            cur_op = b;
            frame_prev = frame_q;
            case (b[7:6])
                2'b01:
                begin
                    loc_q += b[5:0];
                    push_result(OP_ADV_LOC, 0, SEH_NONE, 0, ST_OK);
                end
                2'b10:
                begin
                    reg_q = b[5:0];
                    cur_op = OP_OFFSET;
                    dec_phase = PH_LEB;
                end
                2'b11:
                begin
                    reg_q = b[5:0];
                    push_result(OP_RESTORE6, 0, SEH_NONE, 0, ST_OK);
                end
                default:
                    case (b)
                        OP_NOP, OP_REMEMBER, OP_RESTORE:
                            push_result(b, 0, SEH_NONE, 0, ST_OK);
                        OP_SET_LOC, OP_ADV1, OP_ADV2, OP_ADV4:
                            dec_phase = PH_FIXED;
                        OP_OFS_EXT, OP_RESTX, OP_UNDEF, OP_SAMEV, OP_REGCPY, OP_DEF_CFA,
                        OP_DEF_REG, OP_DEF_OFS, OP_OFS_SF, OP_CFA_SF, OP_SEH, OP_ARGS:
                            dec_phase = PH_LEB;
                        default:
                            push_result(b, 0, SEH_NONE, 0, ST_BAD_OP);
                    endcase
            endcase
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    assign pending_results = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_decode();
            loc_q = 0; reg_q = 0; reg2_q = 0; ofs_q = 0;
            frame_q = 0; frame_prev = 0; level_q = 0; err_q = 0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            // compare the result before predicting; a byte's result shows up later
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result, op_code %h", op_code);
                    fail_count++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    check_field("op_code", e.op_code, op_code);
                    check_field("location", e.location, location);
                    check_field("reg_number", e.reg_number, reg_number);
                    check_field("second_reg", e.second_reg, second_reg);
                    check_field("save_offset", e.save_offset, save_offset);
                    check_field("cfa_offset", e.cfa_offset, cfa_offset);
                    check_field("cfa_delta", e.cfa_delta, cfa_delta);
                    check_field("is_unwind_op", e.is_unwind_op, is_unwind_op);
                    check_field("seh_event", e.seh_event, seh_event);
                    check_field("try_depth", e.try_depth, try_depth);
                    check_field("aux_value", e.aux_value, aux_value);
                    check_field("status", e.status, status);
                end
            end
            if (in_valid && in_ready)
                take_byte(data_byte, start_sequence, base_location);
        end
    end

endmodule

// File: sim/dwarf_cfa_instruction_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Call-frame decoder testbench
// Drives directed and random instruction streams with random gaps on both
// channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module dwarf_cfa_instruction_decoder_test;
    import dcfa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_sequence;
    logic [31:0] base_location;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  op_code;
    logic [31:0] location, reg_number, second_reg, aux_value;
    logic signed [31:0] save_offset, cfa_offset, cfa_delta;
    logic        is_unwind_op;
    logic [2:0]  seh_event, status;
    logic [4:0]  try_depth;
    int          fail_count;
    int          pending_results;
    int          cycle_count;
    int          bytes_sent;
    bit          stall_free;

    dwarf_cfa_instruction_decoder dut (.*);

    dwarf_cfa_instruction_decoder_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, with stall-free stretches.
    initial
    begin
        int unsigned n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = stall_free ? 0 : gap_len();
            out_ready <= (n == 0);
            repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Hold the byte until the transfer, with an optional gap in front.
    task automatic send_byte(logic [7:0] b, logic strt = 1'b0,
                             logic [31:0] base = 32'h0, bit nogap = 0);
        int unsigned n;
        n = (nogap || stall_free) ? 0 : gap_len();
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        start_sequence <= strt;
        base_location  <= base;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_uleb(logic [31:0] v, int unsigned extra = 0);
        do
        begin
            send_byte({(v > 127 || extra != 0), v[6:0]});
            v = v >> 7;
        end
        while (v != 0);
        while (extra != 0)
        begin
            extra--;
            send_byte({(extra != 0), 7'($urandom)});
        end
    endtask

    task automatic send_sleb(int signed v);
        bit done;
        do
        begin
            done = (v >= -64 && v < 64);
            send_byte({!done, v[6:0]});
            v = v >>> 7;
        end
        while (!done);
    endtask

    task automatic send_start(logic [7:0] b);
        send_byte(b, 1'b1, $urandom);
    endtask

    // One random instruction; some are malformed or restart the sequence.
    task automatic send_instruction();
        int unsigned k;
        logic [7:0] op;
        logic [31:0] v;
        k = $urandom_range(0, 21);
        case (k)
            0: send_byte({2'b01, 6'($urandom)});
            1: send_byte({2'b11, 6'($urandom)});
            2:
            begin
                send_byte({2'b10, 6'($urandom)});
                send_uleb($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300));
            end
            3: send_byte(OP_NOP);
            4: send_byte($urandom_range(0, 1) ? OP_REMEMBER : OP_RESTORE);
            5, 6:
            begin
                op = 8'(OP_SET_LOC + $urandom_range(0, 3));
                send_byte(op);
                repeat (op == OP_SET_LOC ? 8 : op == OP_ADV1 ? 1 : op == OP_ADV2 ? 2 : 4)
                    send_byte(8'($urandom));
            end
            7, 8:
            begin
                op = $urandom_range(0, 1) ? OP_OFS_EXT : OP_REGCPY;
                send_byte(op);
                send_uleb($urandom_range(0, 40));
                send_uleb($urandom);
            end
            9:
            begin
                send_byte(OP_OFS_SF);
                send_uleb($urandom_range(0, 40));
                send_sleb($urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 200) - 100);
            end
            10:
            begin
                send_byte(8'(OP_RESTX + $urandom_range(0, 2)));
                send_uleb($urandom_range(0, 200));
            end
            11:
            begin
                send_byte(OP_DEF_REG);
                send_uleb($urandom_range(0, 1) ? $urandom : 1, $urandom_range(0, 1) * 4);
            end
            12:
            begin
                send_byte(OP_DEF_CFA);
                send_uleb($urandom_range(0, 31));
                send_uleb($urandom_range(0, 4096));
            end
            13:
            begin
                send_byte(OP_DEF_OFS);
                send_uleb($urandom);
            end
            14:
            begin
                send_byte(OP_CFA_SF);
                send_uleb($urandom_range(0, 31));
                send_sleb($urandom_range(0, 400) - 200);
            end
            15:
            begin
                send_byte(OP_ARGS);
                send_uleb($urandom);
            end
            16, 17, 18:
            begin
                // mostly begin/end so the try level climbs and falls
                v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9)
                    : ($urandom_range(0, 2) != 0 ? 32'(SEH_BEGIN) : 32'(SEH_END));
                send_byte(OP_SEH);
                send_uleb(v);
                if (v == 32'(SEH_FCONST))
                    send_uleb($urandom);
            end
            19: send_byte(8'($urandom));
            20: send_start($urandom_range(0, 3) == 0 ? 8'($urandom) : OP_NOP);
            default:
            begin
                send_byte(OP_SEH);
                send_uleb(32'(SEH_FCONST));
                send_uleb($urandom);
            end
        endcase
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h0;
        start_sequence = 1'b0;
        base_location  = 32'h0;
        stall_free     = 0;
        bytes_sent     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: packed classes, fixed operands, LEB edge cases, SEH cases.
        send_start(8'h7f);
        send_byte(8'hff);
        send_byte(8'hbf); send_uleb(32'hffff_ffff);
        send_byte(OP_SET_LOC); repeat (8) send_byte(8'hff);
        send_byte(OP_ADV1); send_byte(8'hff);
        send_byte(OP_ADV4); repeat (4) send_byte(8'hff);
        send_byte(OP_OFS_SF); send_uleb(3); send_sleb(-2147483647 - 1);
        send_byte(OP_CFA_SF); send_uleb(7); send_sleb(-1);
        send_byte(OP_DEF_REG); send_uleb(5, 6);
        send_byte(OP_SEH); send_uleb(32'(SEH_END));
        send_start(OP_SEH); send_uleb(0);
        send_start(OP_SEH); send_uleb(32'(SEH_FCONST)); send_uleb(32'h8000_0000);
        repeat (20)
        begin
            send_byte(OP_SEH); send_uleb(32'(SEH_BEGIN));
        end
        send_start(8'h3f);
        send_byte(8'h13);

        // Let everything drain once with the sender held off.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        while (bytes_sent < 1000)
        begin
            stall_free = ($urandom_range(0, 9) == 0);
            send_instruction();
        end
        stall_free = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
